// ===== src/temperature_smoothing_classifier_top_defines.svh =====
// Assertion helpers used by the top-level file to check its own logic.
`ifndef TEMPERATURE_SMOOTHING_CLASSIFIER_TOP_DEFINES_SVH
`define TEMPERATURE_SMOOTHING_CLASSIFIER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tsc_pkg.sv =====
package tsc_pkg;

   // Window and field widths
   localparam int WINDOW    = 5;
   localparam int SAMPLE_W  = 12;
   localparam int LIMIT_W   = 11;
   localparam int MEAN_W    = 11;
   localparam int BAND_W    = 2;
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = $clog2(WINDOW * ((1 << LIMIT_W) - 1) + 1);

   // Radix-4 divider: two quotient bits per step
   localparam int DIV_STEPS = (SUM_W + 1) / 2;
   localparam int DVD_W     = 2 * DIV_STEPS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_MID_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH_LIMIT = 2'd3;

   localparam logic [LIMIT_W-1:0] ALERT_THRESHOLD_RESET = 11'd1280;
   localparam logic [LIMIT_W-1:0] BAND_LOW_LIMIT_RESET  = 11'd640;
   localparam logic [LIMIT_W-1:0] BAND_MID_LIMIT_RESET  = 11'd1040;
   localparam logic [LIMIT_W-1:0] BAND_HIGH_LIMIT_RESET = 11'd1200;

   // Band codes
   localparam logic [BAND_W-1:0] BAND_COOL     = 2'd0;
   localparam logic [BAND_W-1:0] BAND_WARM     = 2'd1;
   localparam logic [BAND_W-1:0] BAND_HOT      = 2'd2;
   localparam logic [BAND_W-1:0] BAND_CRITICAL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } tsc_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // take the sample, update ring and sum, start divide
      logic div_step;  // one radix-4 divide step
      logic out_load;  // classify and fill the result register
   } tsc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sample_ok; // sample on the input is a good reading
   } tsc_status_type;

endpackage

// ===== src/tsc_req_if.sv =====
interface tsc_req_if;
   import tsc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/tsc_rsp_if.sv =====
interface tsc_rsp_if;
   import tsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [MEAN_W-1:0] smoothed;
   logic [BAND_W-1:0] band;
   logic              log_flag;
   logic              alert;

   modport source (output valid, output smoothed, output band, output log_flag,
                   output alert, input ready);
   modport sink   (input valid, input smoothed, input band, input log_flag,
                   input alert, output ready);
endinterface

// ===== src/tsc_ctrl.sv =====
module tsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tsc_pkg::tsc_status_type status,
   output tsc_pkg::tsc_cmd_type    cmd
);
   import tsc_pkg::*;

   tsc_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              last_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.sample_ok) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (last_step) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && status.sample_ok;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: ;
      endcase
   end

   // Step counter for the divider
   always_comb begin
      step_in = '0;
      if (state_ff == ST_DIVIDE) step_in = step_ff + STEP_W'(1);
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/tsc_dp.sv =====
module tsc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tsc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tsc_pkg::LIMIT_W-1:0]           csr_write_data,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0]   sample,
   input  tsc_pkg::tsc_cmd_type                  cmd,
   output tsc_pkg::tsc_status_type               status,
   output logic [tsc_pkg::MEAN_W-1:0]            smoothed,
   output logic [tsc_pkg::BAND_W-1:0]            band,
   output logic                                  log_flag,
   output logic                                  alert
);
   import tsc_pkg::*;

   // Limit registers
   logic [LIMIT_W-1:0] alert_thr_ff, band_low_ff, band_mid_ff, band_high_ff;

   // Window state
   logic [LIMIT_W-1:0] ring_ff [WINDOW];
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // Divider
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;

   // Result payload
   logic [MEAN_W-1:0]  smoothed_ff;
   logic [BAND_W-1:0]  band_ff;
   logic               log_ff, alert_ff;

   logic [LIMIT_W-1:0] raw;
   logic               full;
   logic [SUM_W-1:0]   evict;
   logic [CNT_W+1:0]   part, d1, d2, d3, diff;
   logic [1:0]         qdig;
   logic [MEAN_W-1:0]  mean;
   logic [BAND_W-1:0]  band_sel;

   assign status.sample_ok = !sample[SAMPLE_W-1];
   assign raw              = sample[LIMIT_W-1:0];
   assign full             = (fill_ff == CNT_W'(WINDOW));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alert_thr_ff <= ALERT_THRESHOLD_RESET;
         band_low_ff  <= BAND_LOW_LIMIT_RESET;
         band_mid_ff  <= BAND_MID_LIMIT_RESET;
         band_high_ff <= BAND_HIGH_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ALERT_THRESHOLD: alert_thr_ff <= csr_write_data;
            CSR_BAND_LOW_LIMIT:  band_low_ff  <= csr_write_data;
            CSR_BAND_MID_LIMIT:  band_mid_ff  <= csr_write_data;
            CSR_BAND_HIGH_LIMIT: band_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Ring update: drop the oldest once the window is full
   always_comb begin
      evict   = full ? SUM_W'(ring_ff[slot_ff]) : '0;
      sum_in  = sum_ff - evict + SUM_W'(raw);
      fill_in = full ? fill_ff : fill_ff + CNT_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) ring_ff[slot_ff] <= raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.load) begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   // Radix-4 restoring divide step, quotient shifts into the dividend
   always_comb begin
      part = {rem_ff, dvd_ff[DVD_W-1 -: 2]};
      d1   = (CNT_W+2)'(divisor_ff);
      d2   = d1 << 1;
      d3   = d1 + d2;
      priority if (part >= d3) begin
         qdig = 2'd3;
         diff = part - d3;
      end else if (part >= d2) begin
         qdig = 2'd2;
         diff = part - d2;
      end else if (part >= d1) begin
         qdig = 2'd1;
         diff = part - d1;
      end else begin
         qdig = 2'd0;
         diff = part;
      end
   end

   always_comb begin
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      priority if (cmd.load) begin
         dvd_in     = DVD_W'(sum_in);
         rem_in     = '0;
         divisor_in = fill_in;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[DVD_W-3:0], qdig};
         rem_in = diff[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   // Band classification, limits tested in order
   assign mean = dvd_ff[MEAN_W-1:0];

   always_comb begin
      priority if (mean <= band_low_ff) band_sel = BAND_COOL;
      else if (mean <= band_mid_ff)     band_sel = BAND_WARM;
      else if (mean <= band_high_ff)    band_sel = BAND_HOT;
      else                              band_sel = BAND_CRITICAL;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         smoothed_ff <= mean;
         band_ff     <= band_sel;
         log_ff      <= (mean > band_mid_ff);
         alert_ff    <= (mean > alert_thr_ff);
      end
   end

   assign smoothed = smoothed_ff;
   assign band     = band_ff;
   assign log_flag = log_ff;
   assign alert    = alert_ff;

endmodule

// ===== src/temperature_smoothing_classifier_top.sv =====
// Channel   Direction  Transaction
// req_chan  in         sample (12-bit signed, 1/16 degree)
// rsp_chan  out        smoothed, band, log_flag, alert
// csr_*     in         limit register write (index, 11-bit data)
//
// A good sample updates the window and running sum at its acceptance edge; its
// result then passes through the radix-4 mean divider steps and a classify step
// into the result register. The next sample is taken only once the controller
// is back in idle, after the result has been classified.
// A negative sample is accepted and dropped with no result.
// Reset is synchronous, active high; the window state and limits reset, the
// ring storage does not. One finished result may wait on rsp_chan while the
// next sample is accepted; a second result stalls in the classify step.
`include "temperature_smoothing_classifier_top_defines.svh"

module temperature_smoothing_classifier_top (
   input  logic                          clock,
   input  logic                          reset,
   tsc_req_if.sink                       req_chan,
   tsc_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [tsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tsc_pkg::LIMIT_W-1:0]   csr_write_data
);
   import tsc_pkg::*;

   tsc_cmd_type    cmd;
   tsc_status_type status;

   // Sequencer
   tsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, divider and classifier
   tsc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample           (req_chan.sample),
      .cmd              (cmd),
      .status           (status),
      .smoothed         (rsp_chan.smoothed),
      .band             (rsp_chan.band),
      .log_flag         (rsp_chan.log_flag),
      .alert            (rsp_chan.alert)
   );

   // Checks
   `TSC_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !rsp_chan.valid || rsp_chan.ready, "pending result overwritten")
   `TSC_ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load, !req_chan.ready, "sample accepted while mean in progress")
   `TSC_ASSERT_NEXT(a_divide_follows_load, clock, reset, cmd.load, cmd.div_step, "divider did not start after load")

endmodule
